// File: rtl/core/itar_pkg.sv
`default_nettype none

package itar_pkg;

    localparam int unsigned RADIX_W      = 6;
    localparam int unsigned CHAR_W       = 7;
    localparam int unsigned DIV_STEP_BITS = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_A_LOWER = 7'd97;
    localparam logic [CHAR_W-1:0] ALPHA_OFFSET = 7'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_OUT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d > DIGIT_MAX) begin
            digit_to_ascii = CHAR_A_LOWER + d_ext - ALPHA_OFFSET;
        end else begin
            digit_to_ascii = CHAR_ZERO + d_ext;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/itar_ram.sv
`default_nettype none

module itar_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/integer_to_ascii_radix.sv
// an accepted request runs the divider once per digit, then a read state fetches the first digit
// each digit is one full pass of the shared 8-bit-per-cycle restoring divider by the radix
// digits then leave one per cycle from the digit buffer while i_out_ready is high, most significant first
// no new request is accepted while one is in work
// synchronous active-low reset: sequencer idle, radix back to 10, no clearing pass
`default_nettype none

module integer_to_ascii_radix #(
    parameter int unsigned VALUE_BITS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [6:0]       o_digit_char,
    output logic             o_last_digit
);

    localparam int unsigned STEP_BITS = itar_pkg::DIV_STEP_BITS;
    localparam int unsigned STEPS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int unsigned WORK_BITS = STEPS * STEP_BITS;
    localparam int unsigned STEP_W    = $clog2(STEPS + 1);
    localparam int unsigned IDX_W     = $clog2(VALUE_BITS);
    localparam int unsigned RW        = itar_pkg::RADIX_W;

    itar_pkg::t_state r_state, n_state;

    logic [RW-1:0]        r_radix;
    logic [RW-1:0]        eff_radix;
    logic [WORK_BITS-1:0] r_work, n_work, div_work;
    logic [RW-1:0]        r_rem, n_rem, div_rem;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [IDX_W-1:0]     r_cnt, n_cnt;

    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [RW-1:0]    ram_rdata;

    // saturate radix to the legal range
    always_comb begin
        if (r_radix < itar_pkg::RADIX_MIN) begin
            eff_radix = itar_pkg::RADIX_MIN;
        end else if (r_radix > itar_pkg::RADIX_MAX) begin
            eff_radix = itar_pkg::RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    // shared divider: several restoring steps per cycle
    always_comb begin
        logic [RW:0]          rem_x;
        logic [WORK_BITS-1:0] w;
        logic [RW-1:0]        rm;
        w  = r_work;
        rm = r_rem;
        for (int j = 0; j < STEP_BITS; j++) begin
            rem_x = {rm, w[WORK_BITS-1]};
            w     = {w[WORK_BITS-2:0], 1'b0};
            if (rem_x >= {1'b0, eff_radix}) begin
                rem_x = rem_x - {1'b0, eff_radix};
                w[0]  = 1'b1;
            end
            rm = rem_x[RW-1:0];
        end
        div_work = w;
        div_rem  = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itar_pkg::ST_IDLE;
            r_radix <= itar_pkg::RADIX_RESET;
            r_work  <= '0;
            r_rem   <= '0;
            r_step  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_work  <= n_work;
            r_rem   <= n_rem;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_rem       = r_rem;
        n_step      = r_step;
        n_cnt       = r_cnt;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_cnt;
        unique case (r_state)
            itar_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_work  = WORK_BITS'(i_value[VALUE_BITS-1:0]);
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = itar_pkg::ST_DIV;
                end
            end
            itar_pkg::ST_DIV: begin
                n_work = div_work;
                n_rem  = div_rem;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    ram_we = 1'b1;
                    n_rem  = '0;
                    n_step = '0;
                    if (div_work == '0) begin
                        n_state = itar_pkg::ST_READ;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            itar_pkg::ST_READ: begin
                ram_re  = 1'b1;
                n_state = itar_pkg::ST_OUT;
            end
            itar_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (r_cnt == '0) begin
                        n_state = itar_pkg::ST_IDLE;
                    end else begin
                        n_cnt     = r_cnt - 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = itar_pkg::ST_IDLE;
            end
        endcase
    end

    // digit buffer, least significant digit at index 0
    itar_ram #(
        .WIDTH(RW),
        .DEPTH(VALUE_BITS)
    ) u_digits (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_cnt),
        .i_wdata(div_rem),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_digit_char = itar_pkg::digit_to_ascii(ram_rdata);
    assign o_last_digit = (r_cnt == '0);

endmodule

`default_nettype wire
